// ----- src/rc_pwm_capture_and_smoothing_macros.svh -----
// Assertion macros shared by the pulse capture and smoothing RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef RC_PWM_CAPTURE_AND_SMOOTHING_MACROS_SVH
`define RC_PWM_CAPTURE_AND_SMOOTHING_MACROS_SVH
`ifndef ASSERT_OFF
`define RCPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RCPC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RCPC_ASSERT(lbl, prop, msg)
`define RCPC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- src/rcpc_pkg.sv -----
// Shared types and constants for the pulse capture and smoothing block.
// Used by the controller, the datapath and the top level; no dependencies.
package rcpc_pkg;

    localparam int NUM_CHANNELS  = 8;
    localparam int HISTORY_DEPTH = 4;
    localparam int CH_W          = 3;
    localparam int WIDTH_W       = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CNT_W         = $clog2(NUM_CHANNELS);
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int ROW_W         = WIDTH_W * HISTORY_DEPTH;
    localparam int SUM_W         = WIDTH_W + SLOT_W;
    localparam int MAIN_CHANNELS = 4;
    localparam int HYST          = 3;

    localparam logic [WIDTH_W-1:0] LOW_LIMIT_RESET  = 16'd900;
    localparam logic [WIDTH_W-1:0] HIGH_LIMIT_RESET = 16'd2200;
    localparam logic [WIDTH_W-1:0] THRESHOLD_RESET  = 16'd985;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET      = 16'd1502;
    localparam logic [CH_W-1:0]    EVENT_CHANNEL    = 3'd3;
    localparam logic [MAIN_CHANNELS-1:0] MAIN_MASK  = '1;

    typedef enum logic [1:0] {
        OP_RISE = 2'd0,
        OP_FALL = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_LIMIT  = 2'd0,
        REG_HIGH_LIMIT = 2'd1,
        REG_THRESHOLD  = 2'd2,
        REG_FAILSAFE   = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        KIND_SMOOTHED = 1'b0,
        KIND_GOOD     = 1'b1
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic tick_start;
        logic edge_do;
        logic row_rd;
        logic row_upd;
        logic smooth;
        logic cnt_inc;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic event_hit;
        logic out_last;
    } status_t;

endpackage

// ----- src/rc_pwm_capture_and_smoothing.sv -----
// RC pulse-width capture with per-channel 4-deep smoothing, top level.
// Input words are timestamped edges (rise, fall) or filter ticks; each
// channel uses valid/ready and a word moves when both are high.
// Output words are smoothed widths (one per channel on a tick, last set
// on the final one) or a single all-main-channels-good event word.
// After acceptance every word passes a dispatch state. An edge then goes
// through the edge state and back to idle, or on to the output state if
// it gives an event word. On a filter tick the controller walks the
// channels one at a time through a registered history row read, a row
// write with sum, the mean/hysteresis step and the output handshake.
// One word is in work at a time; the input is not ready until the last
// result of the current word has been taken. A stalled receiver holds
// the output word and the whole block waits.
// Reset restores the register defaults, sets every width to 1502, clears
// rise times, smoothed values and the good mask; history rows read as
// zero until written, so no clearing pass is needed.
// Configuration writes take effect on the next clock edge.
module rc_pwm_capture_and_smoothing (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rcpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rcpc_pkg::WIDTH_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic [rcpc_pkg::CH_W-1:0]         channel,
    input  logic [rcpc_pkg::WIDTH_W-1:0]      timestamp_us,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              kind,
    output logic [rcpc_pkg::CH_W-1:0]         out_channel,
    output logic [rcpc_pkg::WIDTH_W-1:0]      value,
    output logic                              last
);
    import rcpc_pkg::*;

    cmd_t    cmd;
    status_t status;

    rcpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rcpc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .channel      (channel),
        .timestamp_us (timestamp_us),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .out_channel  (out_channel),
        .value        (value),
        .last         (last)
    );

endmodule

// ----- src/rcpc_ctrl.sv -----
// Sequencing controller for the pulse capture and smoothing block.
// Depends on rcpc_pkg for the command and status structs.
`include "rc_pwm_capture_and_smoothing_macros.svh"

module rcpc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  rcpc_pkg::status_t status,
    output rcpc_pkg::cmd_t    cmd
);
    import rcpc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DISPATCH = 7'b0000010,
        ST_EDGE     = 7'b0000100,
        ST_TREAD    = 7'b0001000,
        ST_TSUM     = 7'b0010000,
        ST_TCALC    = 7'b0100000,
        ST_OUT      = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.op)
                    OP_RISE, OP_FALL: state_next = ST_EDGE;
                    OP_TICK:
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = ST_TREAD;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_EDGE:
            begin
                cmd.edge_do = 1'b1;
                state_next  = status.event_hit ? ST_OUT : ST_IDLE;
            end
            ST_TREAD:
            begin
                cmd.row_rd = 1'b1;
                state_next = ST_TSUM;
            end
            ST_TSUM:
            begin
                cmd.row_upd = 1'b1;
                state_next  = ST_TCALC;
            end
            ST_TCALC:
            begin
                cmd.smooth = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (status.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_TREAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `RCPC_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken while a word is pending")
    `RCPC_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready && !out_valid, "bad accept")
    `RCPC_ASSERT_NEXT(a_event_out, cmd.edge_do && status.event_hit, out_valid, "event lost")

endmodule

// ----- src/rcpc_datapath.sv -----
// Datapath: configuration, edge capture, history memory and smoothing.
// Depends on rcpc_pkg; driven by commands from rcpc_ctrl.
`include "rc_pwm_capture_and_smoothing_macros.svh"

module rcpc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rcpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rcpc_pkg::WIDTH_W-1:0]      cfg_data,
    input  logic [1:0]                        opcode,
    input  logic [rcpc_pkg::CH_W-1:0]         channel,
    input  logic [rcpc_pkg::WIDTH_W-1:0]      timestamp_us,
    input  rcpc_pkg::cmd_t                    cmd,
    output rcpc_pkg::status_t                 status,
    output logic                              kind,
    output logic [rcpc_pkg::CH_W-1:0]         out_channel,
    output logic [rcpc_pkg::WIDTH_W-1:0]      value,
    output logic                              last
);
    import rcpc_pkg::*;

    logic [WIDTH_W-1:0]       low_reg;
    logic [WIDTH_W-1:0]       high_reg;
    logic [WIDTH_W-1:0]       thr_reg;
    logic                     fs_reg;

    op_t                      op_reg;
    logic [CH_W-1:0]          ch_reg;
    logic [WIDTH_W-1:0]       ts_reg;

    logic [WIDTH_W-1:0]       rise_reg   [NUM_CHANNELS];
    logic [WIDTH_W-1:0]       pw_reg     [NUM_CHANNELS];
    logic [WIDTH_W-1:0]       smooth_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  row_valid_reg;
    logic [MAIN_CHANNELS-1:0] mask_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [ROW_W-1:0]         row_rd_reg;
    logic [SUM_W-1:0]         sum_reg;

    logic [ROW_W-1:0]         hist_mem [NUM_CHANNELS];

    logic                     ch_ok;
    logic [CNT_W-1:0]         eidx;
    logic [WIDTH_W-1:0]       width;
    logic                     w_ok;
    logic                     mask_set;
    logic [MAIN_CHANNELS-1:0] mask_new;
    logic                     event_hit;

    logic [ROW_W-1:0]         row_cur;
    logic [ROW_W-1:0]         row_new;
    logic [SUM_W-1:0]         row_sum;
    logic [SUM_W-1:0]         sum_rnd;
    logic [WIDTH_W-1:0]       mean;
    logic [WIDTH_W-1:0]       cur;
    logic [WIDTH_W:0]         mean_x;
    logic [WIDTH_W:0]         cur_x;
    logic [WIDTH_W-1:0]       smooth_new;

    // Edge decode on the captured word.
    always_comb
    begin
        ch_ok     = (int'(ch_reg) < NUM_CHANNELS);
        eidx      = CNT_W'(ch_reg);
        width     = ts_reg - rise_reg[eidx];
        w_ok      = (width > low_reg) && (width < high_reg);
        mask_set  = (op_reg == OP_FALL) && w_ok && fs_reg
                    && (int'(ch_reg) < MAIN_CHANNELS) && (width > thr_reg);
        mask_new  = mask_reg;
        if (mask_set)
        begin
            mask_new = mask_reg | (MAIN_CHANNELS'(1) << ch_reg[1:0]);
        end
        event_hit = ch_ok && fs_reg && (ch_reg == EVENT_CHANNEL) && (mask_new == MAIN_MASK);
    end

    // History row update: the new width replaces the current slot.
    always_comb
    begin
        row_cur = row_valid_reg[cnt_reg] ? row_rd_reg : '0;
        row_new = row_cur;
        row_new[slot_reg*WIDTH_W +: WIDTH_W] = pw_reg[cnt_reg];
        row_sum = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            row_sum = row_sum + SUM_W'(row_new[i*WIDTH_W +: WIDTH_W]);
        end
    end

    // Rounded mean followed with hysteresis.
    always_comb
    begin
        sum_rnd    = sum_reg + SUM_W'(HISTORY_DEPTH / 2);
        mean       = sum_rnd[SUM_W-1:SLOT_W];
        cur        = smooth_reg[cnt_reg];
        mean_x     = {1'b0, mean};
        cur_x      = {1'b0, cur};
        smooth_new = cur;
        if (mean_x + (WIDTH_W+1)'(HYST) < cur_x)
        begin
            smooth_new = mean + WIDTH_W'(2);
        end
        else if (mean_x > cur_x + (WIDTH_W+1)'(HYST))
        begin
            smooth_new = mean - WIDTH_W'(2);
        end
    end

    assign status.op        = op_reg;
    assign status.event_hit = event_hit;
    assign status.out_last  = last;

    always_ff @(posedge clk)
    begin
        if (cmd.row_rd)
        begin
            row_rd_reg <= hist_mem[cnt_reg];
        end
        if (cmd.row_upd)
        begin
            hist_mem[cnt_reg] <= row_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= op_t'(opcode);
            ch_reg <= channel;
            ts_reg <= timestamp_us;
        end
        if (cmd.row_upd)
        begin
            sum_reg <= row_sum;
        end
        if (cmd.edge_do && event_hit)
        begin
            kind        <= KIND_GOOD;
            out_channel <= '0;
            value       <= '0;
            last        <= 1'b1;
        end
        else if (cmd.smooth)
        begin
            kind        <= KIND_SMOOTHED;
            out_channel <= CH_W'(cnt_reg);
            value       <= smooth_new;
            last        <= (int'(cnt_reg) == NUM_CHANNELS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= LOW_LIMIT_RESET;
            high_reg      <= HIGH_LIMIT_RESET;
            thr_reg       <= THRESHOLD_RESET;
            fs_reg        <= 1'b1;
            mask_reg      <= '0;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            row_valid_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                rise_reg[i]   <= '0;
                pw_reg[i]     <= WIDTH_RESET;
                smooth_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_LOW_LIMIT:  low_reg  <= cfg_data;
                    REG_HIGH_LIMIT: high_reg <= cfg_data;
                    REG_THRESHOLD:  thr_reg  <= cfg_data;
                    REG_FAILSAFE:   fs_reg   <= cfg_data[0];
                    default:        ;
                endcase
            end
            if (cmd.edge_do && ch_ok)
            begin
                if (op_reg == OP_RISE)
                begin
                    rise_reg[eidx] <= ts_reg;
                end
                else if (w_ok)
                begin
                    pw_reg[eidx] <= width;
                end
                mask_reg <= event_hit ? '0 : mask_new;
            end
            if (cmd.tick_start)
            begin
                slot_reg <= slot_reg + SLOT_W'(1);
                cnt_reg  <= '0;
            end
            if (cmd.row_upd)
            begin
                row_valid_reg[cnt_reg] <= 1'b1;
            end
            if (cmd.smooth)
            begin
                smooth_reg[cnt_reg] <= smooth_new;
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    `RCPC_ASSERT_NEXT(a_mask_clear, cmd.edge_do && event_hit, mask_reg == '0, "mask not cleared")
    `RCPC_ASSERT_NEXT(a_tick_word, cmd.smooth, (kind == KIND_SMOOTHED) && (out_channel == CH_W'($past(cnt_reg))), "bad tick word")
    `RCPC_ASSERT_NEXT(a_row_valid, cmd.row_upd, row_valid_reg[$past(cnt_reg)], "row not marked")

endmodule

// ----- test/rc_pwm_capture_and_smoothing_tb.sv -----
// Self-checking testbench for rc_pwm_capture_and_smoothing: edge and tick words
// go in, and a behavioral copy of the capture and smoothing logic checks every output word.
// Depends on rcpc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module rc_pwm_capture_and_smoothing_tb;
    import rcpc_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        op_t                op;
        logic [CH_W-1:0]    ch;
        logic [WIDTH_W-1:0] ts;
    } in_word_t;

    typedef struct {
        kind_t              kind;
        logic [CH_W-1:0]    ch;
        logic [WIDTH_W-1:0] value;
        logic               last;
    } out_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WIDTH_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           opcode = '0;
    logic [CH_W-1:0]      channel = '0;
    logic [WIDTH_W-1:0]   timestamp_us = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 kind;
    logic [CH_W-1:0]      out_channel;
    logic [WIDTH_W-1:0]   value;
    logic                 last;

    rc_pwm_capture_and_smoothing uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .channel      (channel),
        .timestamp_us (timestamp_us),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_channel  (out_channel),
        .value        (value),
        .last         (last)
    );

    // Shadow copy of the block's registers and state.
    logic [WIDTH_W-1:0]   lo_lim = LOW_LIMIT_RESET;
    logic [WIDTH_W-1:0]   hi_lim = HIGH_LIMIT_RESET;
    logic [WIDTH_W-1:0]   good_thr = THRESHOLD_RESET;
    logic                 fs_en = 1'b1;
    logic [WIDTH_W-1:0]   rise_at [NUM_CHANNELS];
    logic [WIDTH_W-1:0]   width_q [NUM_CHANNELS];
    logic [WIDTH_W-1:0]   smooth_v [NUM_CHANNELS];
    logic [WIDTH_W-1:0]   hist [NUM_CHANNELS][HISTORY_DEPTH];
    logic [SLOT_W-1:0]    slot_idx = '0;
    logic [MAIN_CHANNELS-1:0] good_bits = '0;

    in_word_t  pending_words[$];
    out_word_t width_reports[$];
    in_word_t  cur_word;

    int  words_sent = 0;
    int  words_taken = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  in_gap = 0;
    int  out_stall = 0;
    bit  in_idle_on = 1'b1;
    bit  out_idle_on = 1'b1;
    bit  calm = 1'b0;
    logic [WIDTH_W-1:0] now = '0;

    initial begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            rise_at[c] = '0;
            width_q[c] = WIDTH_RESET;
            smooth_v[c] = '0;
            for (int s = 0; s < HISTORY_DEPTH; s++)
                hist[c][s] = '0;
        end
    end

    initial begin
        forever #1 clk = ~clk;
    end

    // Applies one accepted input word to the shadow state and queues the output
    // words it should produce.
    task automatic decode_edge_or_tick(input in_word_t w);
        logic [WIDTH_W-1:0] span;
        int sum;
        int mean;
        int cur;
        out_word_t r;
        if (w.op == OP_TICK) begin
            slot_idx = slot_idx + 1'b1;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                hist[c][slot_idx] = width_q[c];
                sum = hist[c][0] + hist[c][1] + hist[c][2] + hist[c][3];
                mean = (sum + 2) / 4;
                cur = smooth_v[c];
                // Hysteresis: only follow the mean once it leaves a +/-3 window.
                if (mean < cur - HYST)
                    cur = mean + 2;
                else if (mean > cur + HYST)
                    cur = mean - 2;
                smooth_v[c] = cur[WIDTH_W-1:0];
                r.kind = KIND_SMOOTHED;
                r.ch = c[CH_W-1:0];
                r.value = smooth_v[c];
                r.last = (c == NUM_CHANNELS - 1);
                width_reports.push_back(r);
            end
        end else if (w.op != OP_NONE) begin
            if (w.op == OP_RISE) begin
                rise_at[w.ch] = w.ts;
            end else begin
                span = w.ts - rise_at[w.ch];
                if (span > lo_lim && span < hi_lim) begin
                    width_q[w.ch] = span;
                    if (fs_en && w.ch < MAIN_CHANNELS && span > good_thr)
                        good_bits[w.ch] = 1'b1;
                end
            end
            if (fs_en && w.ch == EVENT_CHANNEL && good_bits == MAIN_MASK) begin
                good_bits = '0;
                r.kind = KIND_GOOD;
                r.ch = '0;
                r.value = '0;
                r.last = 1'b1;
                width_reports.push_back(r);
            end
        end
    endtask

    task automatic add_word(input op_t op, input logic [CH_W-1:0] ch,
                            input logic [WIDTH_W-1:0] ts);
        in_word_t w;
        w.op = op;
        w.ch = ch;
        w.ts = ts;
        pending_words.push_back(w);
        words_sent++;
    endtask

    task automatic add_pulse(input logic [CH_W-1:0] ch, input logic [WIDTH_W-1:0] t0,
                             input logic [WIDTH_W-1:0] span);
        add_word(OP_RISE, ch, t0);
        add_word(OP_FALL, ch, t0 + span);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [WIDTH_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LOW_LIMIT:  lo_lim = v;
            REG_HIGH_LIMIT: hi_lim = v;
            REG_THRESHOLD:  good_thr = v;
            REG_FAILSAFE:   fs_en = v[0];
            default: ;
        endcase
    endtask

    // Waits until every word is taken and answered, then lets the block settle.
    task automatic drain;
        wait (words_taken == words_sent && width_reports.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly complete rise/fall pairs with widths around the limits, plus ticks,
    // lone edges and unused opcodes as noise.
    task automatic random_traffic(input int n_items);
        int made;
        int pick;
        logic [CH_W-1:0]    ch;
        logic [WIDTH_W-1:0] span;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                if ($urandom_range(0, 3) == 0)
                    ch = 3'($urandom_range(4, 7));
                else
                    ch = 3'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0: span = 16'($urandom);
                    1: span = lo_lim + 16'($urandom_range(0, 1));
                    2: span = hi_lim - 16'($urandom_range(0, 1));
                    3: span = good_thr + 16'($urandom_range(0, 1));
                    default: span = 16'($urandom_range(950, 2150));
                endcase
                now = now + 16'($urandom_range(0, 4000));
                add_pulse(ch, now, span);
                now = now + span;
                made += 2;
            end else if (pick < 80) begin
                add_word(OP_TICK, 3'($urandom), 16'($urandom));
                made++;
            end else if (pick < 93) begin
                add_word($urandom_range(0, 1) ? OP_FALL : OP_RISE, 3'($urandom),
                         16'($urandom));
                made++;
            end else begin
                add_word(OP_NONE, 3'($urandom), 16'($urandom));
            end
        end
    endtask

    // Input driver: presents queued words, with random idle bursts between them.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                decode_edge_or_tick(cur_word);
                words_taken++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    opcode <= cur_word.op;
                    channel <= cur_word.ch;
                    timestamp_us <= cur_word.ts;
                    in_valid <= 1'b1;
                    if (!calm && in_idle_on && $urandom_range(0, 3) == 0)
                        in_gap = $urandom_range(1, 13);
                end else begin
                    in_valid <= 1'b0;
                end
            end
            if ($urandom_range(0, 59) == 0)
                in_idle_on = !in_idle_on;
        end
    end

    // Output monitor: checks each taken word against the oldest prediction and
    // throttles out_ready in random bursts.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (width_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] unexpected word: kind %0d ch %0d value %0d last %0d",
                                 $realtime, kind, out_channel, value, last);
                end else begin
                    out_word_t exp_w;
                    exp_w = width_reports.pop_front();
                    if (kind !== exp_w.kind || out_channel !== exp_w.ch ||
                        value !== exp_w.value || last !== exp_w.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"[%0t] word mismatch: expected kind %0d ch %0d ",
                                      "value %0d last %0d, got kind %0d ch %0d value %0d ",
                                      "last %0d"}, $realtime, exp_w.kind, exp_w.ch,
                                     exp_w.value, exp_w.last, kind, out_channel, value, last);
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!calm && out_idle_on && $urandom_range(0, 4) == 0)
                    out_stall = $urandom_range(1, 13);
            end
            if ($urandom_range(0, 59) == 0)
                out_idle_on = !out_idle_on;
        end
    end

    // Watchdog: a long stretch with no word moving on either side means a hang.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset configuration.
        add_word(OP_TICK, 3'd0, 16'h0000);
        add_word(OP_RISE, 3'd0, 16'hFFF0);
        add_word(OP_FALL, 3'd0, 16'h05A0);      // width wraps past zero
        add_pulse(3'd1, 16'd100, 16'd901);      // just above the low limit
        add_pulse(3'd1, 16'd0, 16'd900);        // equal to the low limit
        add_pulse(3'd1, 16'd2000, 16'd2200);    // equal to the high limit
        add_pulse(3'd1, 16'd5000, 16'd2199);
        add_pulse(3'd2, 16'd9000, 16'd1500);
        add_word(OP_RISE, 3'd3, 16'd0);         // mask not yet full
        add_word(OP_FALL, 3'd3, 16'd1800);      // completes the mask
        add_word(OP_NONE, 3'd7, 16'hFFFF);
        add_pulse(3'd7, 16'hFFFF, 16'd1000);
        add_pulse(3'd4, 16'h0000, 16'hFFFF);
        add_pulse(3'd5, 16'h5555, 16'h5555);
        add_word(OP_TICK, 3'd7, 16'hFFFF);
        add_word(OP_FALL, 3'd3, 16'd2100);      // fall without a new rise
        add_word(OP_TICK, 3'd0, 16'h1234);
        drain();

        random_traffic(100);
        drain();

        write_reg(REG_LOW_LIMIT, 16'h0000);
        write_reg(REG_HIGH_LIMIT, 16'hFFFF);
        write_reg(REG_THRESHOLD, 16'h0000);
        write_reg(REG_FAILSAFE, 16'h0001);
        random_traffic(90);
        drain();

        // Nothing can pass these limits, and the good mask is switched off.
        write_reg(REG_LOW_LIMIT, 16'hFFFF);
        write_reg(REG_HIGH_LIMIT, 16'h0000);
        write_reg(REG_THRESHOLD, 16'hFFFF);
        write_reg(REG_FAILSAFE, 16'hFFFE);
        random_traffic(60);
        drain();

        write_reg(REG_LOW_LIMIT, 16'd1000);
        write_reg(REG_HIGH_LIMIT, 16'd2000);
        write_reg(REG_THRESHOLD, 16'd1500);
        write_reg(REG_FAILSAFE, 16'h0001);
        random_traffic(90);
        drain();

        write_reg(REG_LOW_LIMIT, LOW_LIMIT_RESET);
        write_reg(REG_HIGH_LIMIT, HIGH_LIMIT_RESET);
        write_reg(REG_THRESHOLD, THRESHOLD_RESET);
        write_reg(REG_FAILSAFE, 16'h0000);
        random_traffic(60);
        drain();

        // Final stretch at full rate on both sides.
        write_reg(REG_FAILSAFE, 16'hFFFF);
        calm = 1'b1;
        random_traffic(60);
        drain();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
